[rtl/assert_macros.svh]
// Assertion macros used by the checker module of the packet counter table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ipct_pkg.sv]
// Package with the types and constants of the IPv4 packet counter table.
`timescale 1ns / 1ps

package ipct_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int ADDR_W = 32;
    localparam int COUNT_W = 32;
    localparam int TOTAL_W = 63;
    localparam int SLOT_W = 8;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic {
        CMD_COUNT = 1'b0,
        CMD_CLEAR = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_NEW     = 2'd0,
        ST_UPDATED = 2'd1,
        ST_FULL    = 2'd2,
        ST_CLEARED = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t               command;
        logic [ADDR_W-1:0]  address;
        logic [COUNT_W-1:0] packet_count;
    } in_t;

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [TOTAL_W-1:0] total;
    } out_t;

endpackage

[rtl/ip_packet_counter_table.sv]
// Top level of the IPv4 packet counter table with its lookup and update pipeline.
//
// Usage: items arrive on the s_ channel (valid/ready). A count command looks up its
// address among the filled slots, adds the packet count to that slot's total with
// saturation, or fills the next free slot; with no free slot the transfer is dropped
// and flagged. A clear command empties the table. Every input transfer yields exactly
// one result transfer on the m_ channel, in order.
// Items pass the s1 input register, the s2 lookup register and the result register.
// Throughput: one item per cycle when no stall holds; the address compare runs against
// all slot registers in parallel, and the totals live in a RAM whose read-after-write
// hazard between neighboring items is covered by a one-entry forwarding register.
// Reset: the fill count and all valid flags clear; the table contents need no clearing
// because only slots below the fill count can match or give a total that is used.
// Stall: when the result register holds a transfer that is not taken, the whole
// pipeline holds and s_ready stays low until m_ready returns.
`timescale 1ns / 1ps

module ip_packet_counter_table #(
    parameter int TABLE_ENTRIES = ipct_pkg::TABLE_ENTRIES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ipct_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output ipct_pkg::out_t m_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [USED_W-1:0] USED_FULL = USED_W'(TABLE_ENTRIES);

    typedef struct packed {
        ipct_pkg::status_t             status;
        logic [IDX_W-1:0]              idx;
        logic [ipct_pkg::COUNT_W-1:0]  count;
    } lookup_t;

    logic                                advance;
    logic                                s1_valid_reg;
    ipct_pkg::in_t                       s1_data_reg;
    logic                                s2_valid_reg;
    lookup_t                             s2_data_reg;
    lookup_t                             s2_next;
    logic                                m_valid_reg;
    ipct_pkg::out_t                      m_data_reg;
    ipct_pkg::out_t                      m_data_next;
    logic [USED_W-1:0]                   used_reg;
    logic [ipct_pkg::ADDR_W-1:0]         cam_addr_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]            match;
    logic                                hit;
    logic                                full;
    logic [IDX_W-1:0]                    hit_idx;
    logic [IDX_W-1:0]                    new_idx;
    logic                                insert;
    logic [ipct_pkg::TOTAL_W-1:0]        ram_rd_data;
    logic                                fwd_valid_reg;
    logic [IDX_W-1:0]                    fwd_idx_reg;
    logic [ipct_pkg::TOTAL_W-1:0]        fwd_total_reg;
    logic [ipct_pkg::TOTAL_W-1:0]        base_total;
    logic [ipct_pkg::TOTAL_W:0]          sum;
    logic [ipct_pkg::TOTAL_W-1:0]        new_total;
    logic                                writes_total;
    logic                                ram_wr_en;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    always_comb begin
        match = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            match[i] = (USED_W'(i) < used_reg) && (cam_addr_reg[i] == s1_data_reg.address);
        end
    end

    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (match[i]) begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    assign hit = |match;
    assign full = (used_reg == USED_FULL);
    assign new_idx = used_reg[IDX_W-1:0];
    assign insert = s1_valid_reg && (s1_data_reg.command == ipct_pkg::CMD_COUNT) && !hit && !full;

    always_comb begin
        s2_next.count = s1_data_reg.packet_count;
        s2_next.idx = '0;
        if (s1_data_reg.command == ipct_pkg::CMD_CLEAR) begin
            s2_next.status = ipct_pkg::ST_CLEARED;
        end else if (hit) begin
            s2_next.status = ipct_pkg::ST_UPDATED;
            s2_next.idx = hit_idx;
        end else if (full) begin
            s2_next.status = ipct_pkg::ST_FULL;
        end else begin
            s2_next.status = ipct_pkg::ST_NEW;
            s2_next.idx = new_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            used_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            m_valid_reg <= s2_valid_reg;
            fwd_valid_reg <= ram_wr_en;
            if (s1_valid_reg && (s1_data_reg.command == ipct_pkg::CMD_CLEAR)) begin
                used_reg <= '0;
            end else if (insert) begin
                used_reg <= used_reg + USED_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_data_reg <= s_data;
            s2_data_reg <= s2_next;
            m_data_reg <= m_data_next;
            fwd_idx_reg <= s2_data_reg.idx;
            fwd_total_reg <= new_total;
            if (insert) begin
                cam_addr_reg[new_idx] <= s1_data_reg.address;
            end
        end
    end

    ipct_ram #(
        .WIDTH(ipct_pkg::TOTAL_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_total_ram (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(s2_data_reg.idx),
        .wr_data(new_total),
        .rd_en  (advance),
        .rd_addr(hit_idx),
        .rd_data(ram_rd_data)
    );

    // The RAM returns the old total when the item ahead wrote the same slot on the read edge.
    assign base_total = (fwd_valid_reg && (fwd_idx_reg == s2_data_reg.idx)) ?
                        fwd_total_reg : ram_rd_data;
    assign sum = {1'b0, base_total} + (ipct_pkg::TOTAL_W + 1)'(s2_data_reg.count);

    always_comb begin
        if (s2_data_reg.status == ipct_pkg::ST_NEW) begin
            new_total = ipct_pkg::TOTAL_W'(s2_data_reg.count);
        end else if (sum[ipct_pkg::TOTAL_W]) begin
            new_total = ipct_pkg::TOTAL_MAX;
        end else begin
            new_total = sum[ipct_pkg::TOTAL_W-1:0];
        end
    end

    assign writes_total = (s2_data_reg.status == ipct_pkg::ST_NEW) ||
                          (s2_data_reg.status == ipct_pkg::ST_UPDATED);
    assign ram_wr_en = advance && s2_valid_reg && writes_total;

    always_comb begin
        m_data_next.status = s2_data_reg.status;
        m_data_next.slot = writes_total ? ipct_pkg::SLOT_W'(s2_data_reg.idx) : '0;
        m_data_next.total = writes_total ? new_total : '0;
    end

endmodule

[rtl/ipct_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module ipct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/ipct_checker.sv]
// Port-level checker for the IPv4 packet counter table, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ipct_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input ipct_pkg::out_t m_data
);

    `ASSERT_CLK_RST(a_result_held, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")

    `ASSERT_CLK(a_reset_empties, aclk, !aresetn |=> !m_valid, "result valid right after reset")

    `ASSERT_CLK(a_ready_only_stall, aclk, !s_ready |-> m_valid && !m_ready, "input stalled without an output stall")

    `ASSERT_CLK_RST(a_no_slot_payload, aclk, aresetn, m_valid && (m_data.status == ipct_pkg::ST_FULL || m_data.status == ipct_pkg::ST_CLEARED) |-> m_data.slot == 0 && m_data.total == 0, "dropped or cleared transfer carries a slot or total")

    `ASSERT_CLK_RST(a_stall_blocks_input, aclk, aresetn, s_valid && !s_ready |=> s_valid, "input transfer withdrawn before acceptance")

endmodule

bind ip_packet_counter_table ipct_checker u_ipct_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

[verif/tb_ip_packet_counter_table.sv]
// Self-checking testbench for the IPv4 packet counter table with directed and random stimulus and stalls.
`timescale 1ns / 1ps

module tb_ip_packet_counter_table;
    import ipct_pkg::*;

    localparam int ENTRIES = TABLE_ENTRIES_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD = 250;

    typedef struct {
        in_t data;
        int  gap;
        bit  drain;
    } report_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    report_item_t pending_reports[$];
    out_t predicted_updates[$];

    logic [ADDR_W-1:0] tbl_address[ENTRIES];
    logic [TOTAL_W-1:0] tbl_total[ENTRIES];
    int fill_count = 0;

    int error_count = 0;
    int accepted_reports = 0;
    int idle_cycles = 0;
    int quiet_left = 0;
    int gap_left = 0;
    bit head_loaded = 1'b0;
    int stall_left = 0;
    int ready_streak = 0;
    int next_hold_at = 120;

    ip_packet_counter_table #(
        .TABLE_ENTRIES(ENTRIES)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic out_t account_report(in_t item);
        out_t res;
        logic [TOTAL_W:0] sum;
        res = '0;
        if (item.command == CMD_CLEAR) begin
            fill_count = 0;
            res.status = ST_CLEARED;
            return res;
        end
        for (int i = 0; i < fill_count; i++) begin
            if (tbl_address[i] == item.address) begin
                sum = {1'b0, tbl_total[i]} + (TOTAL_W + 1)'(item.packet_count);
                tbl_total[i] = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
                res.status = ST_UPDATED;
                res.slot = SLOT_W'(i);
                res.total = tbl_total[i];
                return res;
            end
        end
        if (fill_count >= ENTRIES) begin
            res.status = ST_FULL;
            return res;
        end
        tbl_address[fill_count] = item.address;
        tbl_total[fill_count] = TOTAL_W'(item.packet_count);
        res.status = ST_NEW;
        res.slot = SLOT_W'(fill_count);
        res.total = tbl_total[fill_count];
        fill_count++;
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, field, got, want);
        error_count++;
    endtask

    function automatic int pick_gap();
        int unsigned r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 4) return COUNT_W'($urandom_range(1, 100));
        return $urandom;
    endfunction

    task automatic add_report(cmd_t cmd, logic [ADDR_W-1:0] addr, logic [COUNT_W-1:0] cnt,
                              bit drain);
        report_item_t item;
        item.data.command = cmd;
        item.data.address = addr;
        item.data.packet_count = cnt;
        item.gap = pick_gap();
        item.drain = drain;
        pending_reports.push_back(item);
    endtask

    always @(posedge aclk) begin : driver
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
            head_loaded = 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                predicted_updates.push_back(account_report(s_data));
                accepted_reports++;
            end
            if (!s_valid || s_ready) begin
                if (pending_reports.size() == 0) begin
                    s_valid <= 1'b0;
                end else begin
                    if (!head_loaded) begin
                        gap_left = pending_reports[0].gap;
                        head_loaded = 1'b1;
                    end
                    if (gap_left > 0) begin
                        gap_left--;
                        s_valid <= 1'b0;
                    end else if (pending_reports[0].drain && predicted_updates.size() != 0) begin
                        s_valid <= 1'b0;
                    end else begin
                        s_valid <= 1'b1;
                        s_data <= pending_reports[0].data;
                        void'(pending_reports.pop_front());
                        head_loaded = 1'b0;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor
        out_t want;
        int unsigned r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_updates.size() == 0) begin
                    report_mismatch("unexpected result status", m_data.status, 0);
                end else begin
                    want = predicted_updates.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch("status", m_data.status, want.status);
                    if (m_data.slot !== want.slot)
                        report_mismatch("slot", m_data.slot, want.slot);
                    if (m_data.total !== want.total)
                        report_mismatch("total", m_data.total, want.total);
                end
            end
            if (stall_left == 0 && accepted_reports >= next_hold_at) begin
                stall_left = LONG_HOLD;
                next_hold_at += 350;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (ready_streak > 0) begin
                    ready_streak--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 8) ready_streak = $urandom_range(20, 80);
                    else if (r < 50) stall_left = 0;
                    else if (r < 85) stall_left = $urandom_range(1, 3);
                    else if (r < 97) stall_left = $urandom_range(4, 12);
                    else stall_left = $urandom_range(20, 50);
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] pool[16];
        int fresh;
        int pool_size;
        int run_len;
        int unsigned r;

        // Directed part: field extremes, zero counts, repeats back to back, clears.
        add_report(CMD_CLEAR, '0, '0, 1'b0);
        add_report(CMD_COUNT, '0, '0, 1'b0);
        add_report(CMD_COUNT, '1, '1, 1'b0);
        add_report(CMD_COUNT, '1, '1, 1'b0);
        add_report(CMD_COUNT, '0, '0, 1'b0);
        add_report(CMD_COUNT, '0, 32'd1, 1'b0);
        add_report(CMD_COUNT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        add_report(CMD_COUNT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        add_report(CMD_COUNT, 32'h0A00_0001, 32'd1, 1'b0);
        add_report(CMD_COUNT, 32'h0A00_0001, 32'd2, 1'b0);
        add_report(CMD_COUNT, 32'h0A00_0001, 32'd3, 1'b0);
        add_report(CMD_COUNT, 32'hAAAA_AAAA, '1, 1'b0);
        add_report(CMD_COUNT, 32'h5555_5555, '1, 1'b0);
        add_report(CMD_COUNT, 32'hAAAA_AAAA, '1, 1'b0);
        add_report(CMD_COUNT, 32'h5555_5555, 32'd7, 1'b0);
        add_report(CMD_CLEAR, '1, '1, 1'b1);
        add_report(CMD_COUNT, 32'h0A00_0001, 32'd9, 1'b0);
        add_report(CMD_COUNT, '1, 32'd4, 1'b0);
        add_report(CMD_COUNT, 32'h0A00_0001, '0, 1'b0);
        add_report(CMD_CLEAR, 32'h1234_5678, 32'h8765_4321, 1'b0);

        // Fill the table past its capacity, mixing in repeats of earlier addresses.
        base = $urandom;
        add_report(CMD_CLEAR, $urandom, $urandom, 1'b1);
        fresh = 0;
        while (fresh < ENTRIES + 34) begin
            if (fresh > 0 && $urandom_range(0, 99) < 25) begin
                addr = {base[ADDR_W-1:9], 9'($urandom_range(0, fresh - 1))};
            end else begin
                addr = {base[ADDR_W-1:9], 9'(fresh)};
                fresh++;
            end
            add_report(CMD_COUNT, addr, pick_count(), 1'b0);
        end

        // Short runs on small address pools, with stray addresses and clears as noise.
        while (pending_reports.size() < 850) begin
            pool_size = $urandom_range(2, 16);
            for (int k = 0; k < pool_size; k++) begin
                pool[k] = $urandom;
            end
            if ($urandom_range(0, 9) < 7) begin
                add_report(CMD_CLEAR, $urandom, $urandom, $urandom_range(0, 3) == 0);
            end
            run_len = $urandom_range(20, 60);
            for (int j = 0; j < run_len; j++) begin
                r = $urandom_range(0, 99);
                if (r < 3) add_report(CMD_CLEAR, $urandom, $urandom, 1'b0);
                else if (r < 10) add_report(CMD_COUNT, $urandom, pick_count(), 1'b0);
                else add_report(CMD_COUNT, pool[$urandom_range(0, pool_size - 1)],
                                pick_count(), 1'b0);
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reports.size() != 0 || s_valid) @(posedge aclk);
        while (predicted_updates.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/ipct_pkg.sv
rtl/ipct_ram.sv
rtl/ip_packet_counter_table.sv
rtl/ipct_checker.sv
verif/tb_ip_packet_counter_table.sv
